@@ hw/rtl/sha1p_pkg.sv @@
`default_nettype none
package sha1p_pkg;

    localparam int WORD_W      = 32;
    localparam int DIGEST_N    = 5;
    localparam int BLOCK_DEPTH = 16;
    localparam int FILL_W      = $clog2(BLOCK_DEPTH);
    localparam int ROUND_N     = 80;
    localparam int ROUND_W     = $clog2(ROUND_N);
    localparam int IDX_W       = $clog2(DIGEST_N);

    typedef logic [DIGEST_N-1:0][WORD_W-1:0] chain_t;

    typedef struct packed {
        logic   done;
        chain_t chain;
    } core_stat_t;

    localparam chain_t CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WORD_W-1:0] K_ROUND0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] PAD_MARKER = 32'h80000000;

    localparam logic [1:0] MODE_START        = 2'd0;
    localparam logic [1:0] MODE_CONTINUE     = 2'd1;
    localparam logic [1:0] MODE_FINISH       = 2'd2;
    localparam logic [1:0] MODE_START_FINISH = 2'd3;

    localparam logic [2:0] FULL_WORD = 3'd4;

    // keep the leading valid bytes and place the 0x80 marker right after them
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] data,
                                                   input logic [1:0]        nbytes);
        logic [WORD_W-1:0] res;
        unique case (nbytes)
            2'd0: res = 32'h80000000;
            2'd1: res = {data[31:24], 24'h800000};
            2'd2: res = {data[31:16], 16'h8000};
            2'd3: res = {data[31:8], 8'h80};
            default: res = 32'h80000000;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha1_hash_with_padding.sv @@
// sha-1 engine with message padding
// input channel (in_valid/in_ready): one big-endian 32-bit message word per
// transaction, with mode (start, continue, finish, start+finish) and
// byte_count (valid leading bytes, 5..7 count as 4)
// output channel (out_valid/out_ready): digest_word, word_index, status, last
// a full word with start or continue is absorbed and gives no output; the word
// that fills a 16-word block adds one compression (one schedule load, 80 rounds
// at one round per cycle, chaining add)
// the compression loop limits throughput: no input word is taken while it runs
// a partial word outside finish gives one error transaction (status 1, last 1)
// finish writes the padding words into the block memory, runs one or two
// compressions, then presents five digest words, last on index 4; the engine
// then starts over with the initial chaining values
// in_ready is high only while the engine is idle; a stalled receiver holds the
// output register and the digest sequence waits for it
// reset loads the initial chaining values and clears length and fill count;
// the block memory needs no clearing since only written entries are read
`default_nettype none
module sha1_hash_with_padding
    import sha1p_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        mode,
    input  wire logic [WORD_W-1:0] data_word,
    input  wire logic [2:0]        byte_count,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [WORD_W-1:0] digest_word,
    output logic      [2:0]        word_index,
    output logic                   status,
    output logic                   last
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MARK     = 8'b0000_0010,
        ST_ZERO     = 8'b0000_0100,
        ST_HI       = 8'b0000_1000,
        ST_LO       = 8'b0001_0000,
        ST_COMPRESS = 8'b0010_0000,
        ST_ERR      = 8'b0100_0000,
        ST_DIGEST   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next, after;
    logic [FILL_W-1:0] fill_reg, fill_next, push_fill;
    logic [63:0] len_reg, len_next, base_len;
    chain_t chain_reg, chain_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic start_reg, start_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] digest_reg, digest_next;
    logic [2:0]        index_reg, index_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;

    logic              push_en;
    logic [WORD_W-1:0] push_data;
    logic              out_free;
    logic [2:0]        cnt;
    logic              start_msg, finishing;

    logic [FILL_W-1:0] core_raddr;
    logic [WORD_W-1:0] ram_rdata;
    core_stat_t        core_stat;

    sha1p_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_DEPTH)
    ) u_block_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (push_fill),
        .wdata (push_data),
        .raddr (core_raddr),
        .rdata (ram_rdata)
    );

    sha1p_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .chain_in (chain_reg),
        .raddr    (core_raddr),
        .rdata    (ram_rdata),
        .stat     (core_stat)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign cnt       = (byte_count > FULL_WORD) ? FULL_WORD : byte_count;
    assign start_msg = (mode == MODE_START) || (mode == MODE_START_FINISH);
    assign finishing = (mode == MODE_FINISH) || (mode == MODE_START_FINISH);
    assign base_len  = start_msg ? 64'd0 : len_reg;

    always_comb
    begin
        after          = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        chain_next     = chain_reg;
        idx_next       = idx_reg;
        start_next     = 1'b0;
        push_en        = 1'b0;
        push_data      = '0;
        push_fill      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digest_next    = digest_reg;
        index_next     = index_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_msg)
                    begin
                        chain_next = CHAIN_INIT;
                        push_fill  = '0;
                        fill_next  = '0;
                    end
                    len_next = base_len;
                    if (!finishing)
                    begin
                        if (cnt != FULL_WORD)
                        begin
                            after = ST_ERR;
                        end
                        else
                        begin
                            push_en   = 1'b1;
                            push_data = data_word;
                            len_next  = base_len + 64'd32;
                            after     = ST_IDLE;
                        end
                    end
                    else
                    begin
                        push_en  = 1'b1;
                        len_next = base_len + {58'd0, cnt, 3'b000};
                        if (cnt == FULL_WORD)
                        begin
                            push_data = data_word;
                            after     = ST_MARK;
                        end
                        else
                        begin
                            push_data = pad_word(data_word, cnt[1:0]);
                            after     = ST_ZERO;
                        end
                    end
                end
            end
            ST_MARK:
            begin
                push_en   = 1'b1;
                push_data = PAD_MARKER;
                after     = ST_ZERO;
            end
            ST_ZERO:
            begin
                // a fill of 15 zero-fills the rest of this block, then an extra block up to the length
                if (fill_reg == FILL_W'(BLOCK_DEPTH - 2))
                begin
                    after = ST_HI;
                end
                else
                begin
                    push_en = 1'b1;
                    after   = ST_ZERO;
                end
            end
            ST_HI:
            begin
                push_en   = 1'b1;
                push_data = len_reg[63:32];
                after     = ST_LO;
            end
            ST_LO:
            begin
                push_en   = 1'b1;
                push_data = len_reg[31:0];
                after     = ST_DIGEST;
            end
            ST_COMPRESS:
            begin
                if (core_stat.done)
                begin
                    chain_next = core_stat.chain;
                    after      = ret_reg;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = '0;
                    index_next     = '0;
                    status_next    = 1'b1;
                    last_next      = 1'b1;
                    after          = ST_IDLE;
                end
            end
            ST_DIGEST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = chain_reg[idx_reg];
                    index_next     = 3'(idx_reg);
                    status_next    = 1'b0;
                    last_next      = (idx_reg == IDX_W'(DIGEST_N - 1));
                    if (idx_reg == IDX_W'(DIGEST_N - 1))
                    begin
                        idx_next   = '0;
                        chain_next = CHAIN_INIT;
                        len_next   = '0;
                        fill_next  = '0;
                        after      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                after = ST_IDLE;
            end
        endcase

        state_next = after;
        if (push_en)
        begin
            fill_next = push_fill + FILL_W'(1);
            if (push_fill == FILL_W'(BLOCK_DEPTH - 1))
            begin
                state_next = ST_COMPRESS;
                ret_next   = after;
                start_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            chain_reg     <= CHAIN_INIT;
            idx_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            chain_reg     <= chain_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
        index_reg  <= index_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMPRESS |-> !push_en)
        else $error("block memory written during compression");

    a_done_in_compress: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == ST_COMPRESS)
        else $error("compression finished outside compress state");

    a_start_follows_full: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == ST_COMPRESS && fill_reg == '0)
        else $error("compression started without a full block");

    a_last_digest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg && !status_reg |-> index_reg == 3'(DIGEST_N - 1))
        else $error("last flag on a digest word other than the final one");

endmodule
`default_nettype wire

@@ hw/rtl/sha1p_ram.sv @@
`default_nettype none
module sha1p_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/sha1p_core.sv @@
`default_nettype none
module sha1p_core
    import sha1p_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire chain_t              chain_in,
    output logic      [FILL_W-1:0]   raddr,
    input  wire logic [WORD_W-1:0]   rdata,
    output core_stat_t               stat
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FINAL = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0] a_next, b_next, c_next, d_next, e_next;
    logic [BLOCK_DEPTH-1:0][WORD_W-1:0] win_reg, win_next;

    logic [WORD_W-1:0] w_cur, w_mix, f_val, k_val, tmp;

    // message schedule: first 16 words come straight from the block memory
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur = (round_reg < ROUND_W'(BLOCK_DEPTH)) ? rdata
                                                       : {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        priority if (round_reg < ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_ROUND0;
        end
        else if (round_reg < ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND1;
        end
        else if (round_reg < ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_ROUND2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND3;
        end
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // read one word ahead of the round that uses it
    assign raddr = (state_reg == C_ROUND) ? (round_reg[FILL_W-1:0] + FILL_W'(1))
                                          : '0;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        win_next   = win_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    a_next     = chain_in[0];
                    b_next     = chain_in[1];
                    c_next     = chain_in[2];
                    d_next     = chain_in[3];
                    e_next     = chain_in[4];
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                a_next   = tmp;
                b_next   = a_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                d_next   = c_reg;
                e_next   = d_reg;
                win_next = {w_cur, win_reg[BLOCK_DEPTH-1:1]};
                if (round_reg == ROUND_W'(ROUND_N - 1))
                begin
                    state_next = C_FINAL;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                end
            end
            C_FINAL:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        win_reg <= win_next;
    end

    assign stat.done     = (state_reg == C_FINAL);
    assign stat.chain[0] = chain_in[0] + a_reg;
    assign stat.chain[1] = chain_in[1] + b_reg;
    assign stat.chain[2] = chain_in[2] + c_reg;
    assign stat.chain[3] = chain_in[3] + d_reg;
    assign stat.chain[4] = chain_in[4] + e_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.done)
        else $error("compression done held longer than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == C_IDLE)
        else $error("compression started while busy");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_ROUND |-> round_reg < ROUND_W'(ROUND_N))
        else $error("round counter out of range");

endmodule
`default_nettype wire

@@ sim/sha1_hash_with_padding_test.sv @@
`timescale 1ns / 1ps

module sha1_hash_with_padding_test;
    import sha1p_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [WORD_W-1:0] digest;
        logic [2:0]        idx;
        logic              status;
        logic              last;
    } digest_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        mode = MODE_START;
    logic [WORD_W-1:0] data_word = '0;
    logic [2:0]        byte_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] digest_word;
    logic [2:0]        word_index;
    logic              status;
    logic              last;

    // predicted engine state
    logic [WORD_W-1:0] hash_words [DIGEST_N];
    logic [63:0]       msg_bits;
    logic [WORD_W-1:0] msg_block [BLOCK_DEPTH];
    int unsigned       block_fill;

    digest_beat_t digest_q[$];

    int send_idle = 0;
    int recv_idle = 0;
    int sent_items = 0;
    int fail_count = 0;
    int stall_cycles = 0;

    sha1_hash_with_padding dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    function automatic void sha1_compress();
        logic [WORD_W-1:0] w [80];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, x, t_sum;
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int t = 0; t < 16; t++)
            w[t] = msg_block[t];
        for (int t = 16; t < 80; t++)
        begin
            x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
            w[t] = {x[30:0], x[31]};
        end
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t_sum = {a[26:0], a[31:27]} + f + e + k + w[t];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t_sum;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    function automatic void sha1_absorb_word(input logic [WORD_W-1:0] w);
        msg_block[block_fill] = w;
        block_fill++;
        if (block_fill == BLOCK_DEPTH)
        begin
            sha1_compress();
            block_fill = 0;
        end
    endfunction

    function automatic void sha1_restart();
        for (int i = 0; i < DIGEST_N; i++)
            hash_words[i] = CHAIN_INIT[i];
        msg_bits = '0;
        block_fill = 0;
    endfunction

    // work out the digest transactions that one accepted input word causes
    function automatic void sha1_take_item(input logic [1:0] m, input logic [WORD_W-1:0] d,
                                           input logic [2:0] cnt);
        int unsigned       nbytes;
        logic              finishing;
        logic [WORD_W-1:0] keep_mask;
        digest_beat_t      beat;
        nbytes = (cnt > FULL_WORD) ? 4 : cnt;
        finishing = (m == MODE_FINISH) || (m == MODE_START_FINISH);
        if (m == MODE_START || m == MODE_START_FINISH)
            sha1_restart();
        if (!finishing)
        begin
            if (nbytes < 4)
            begin
                beat = '{digest: '0, idx: '0, status: 1'b1, last: 1'b1};
                digest_q.push_back(beat);
            end
            else
            begin
                sha1_absorb_word(d);
                msg_bits += 32;
            end
            return;
        end
        if (nbytes == 4)
        begin
            sha1_absorb_word(d);
            sha1_absorb_word(PAD_MARKER);
        end
        else
        begin
            keep_mask = ~(32'hFFFFFFFF >> (8 * nbytes));
            if (nbytes == 0)
                keep_mask = '0;
            sha1_absorb_word((d & keep_mask) | (PAD_MARKER >> (8 * nbytes)));
        end
        msg_bits += 8 * nbytes;
        // no room for the length field, so pad out a second block
        if (block_fill > 14)
            while (block_fill != 0)
                sha1_absorb_word('0);
        while (block_fill < 14)
            sha1_absorb_word('0);
        sha1_absorb_word(msg_bits[63:32]);
        sha1_absorb_word(msg_bits[31:0]);
        for (int i = 0; i < DIGEST_N; i++)
        begin
            beat = '{digest: hash_words[i], idx: 3'(i), status: 1'b0,
                     last: (i == DIGEST_N - 1)};
            digest_q.push_back(beat);
        end
        sha1_restart();
    endfunction

    always @(posedge clk)
    begin : check_results
        digest_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: unexpected result digest %h index %0d status %0d last %0d",
                             $realtime, digest_word, word_index, status, last);
                fail_count++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (digest_word !== want.digest || word_index !== want.idx ||
                    status !== want.status || last !== want.last)
                begin
                    if (fail_count < 10)
                        $display("%0t: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 $realtime, want.digest, want.idx, want.status, want.last,
                                 digest_word, word_index, status, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sha1_hash_with_padding: mismatch");
            $finish;
        end
    end

    // one input transaction; with drain set, wait until every digest is out first
    task automatic send_item(input logic [1:0] m, input logic [WORD_W-1:0] d,
                             input logic [2:0] cnt, input bit drain = 1'b0);
        int gap;
        gap = 0;
        if (send_idle != 0)
            while ($urandom_range(99) < send_idle)
                gap++;
        if (drain || gap != 0)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (drain && digest_q.size() != 0)
                @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        data_word <= d;
        byte_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sha1_take_item(m, d, cnt);
        sent_items++;
    endtask

    function automatic logic [2:0] full_count();
        return ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : FULL_WORD;
    endfunction

    task automatic test_single_word_messages();
        send_item(MODE_START_FINISH, 32'hFFFFFFFF, 3'd0);
        send_item(MODE_START_FINISH, 32'h616263FF, 3'd3);
        send_item(MODE_START_FINISH, 32'hFFFFFFFF, 3'd4);
        send_item(MODE_START_FINISH, 32'h00000000, 3'd7);
    endtask

    task automatic test_partial_word_errors();
        send_item(MODE_START, 32'hFFFFFFFF, 3'd2);
        send_item(MODE_CONTINUE, 32'h00000000, 3'd0);
        send_item(MODE_CONTINUE, 32'h12345678, 3'd4);
        send_item(MODE_FINISH, 32'hFFFFFFFF, 3'd1);
        send_item(MODE_START, 32'hFFFFFFFF, 3'd5);
        send_item(MODE_CONTINUE, 32'h00000000, 3'd6);
        send_item(MODE_CONTINUE, 32'hA5A5A5A5, 3'd3);
        send_item(MODE_FINISH, 32'h5A5A5A5A, 3'd2);
    endtask

    // 14 message words plus the marker leave no room for the length
    task automatic test_two_block_padding();
        send_item(MODE_START, $urandom(), FULL_WORD);
        repeat (12) send_item(MODE_CONTINUE, $urandom(), FULL_WORD);
        send_item(MODE_FINISH, $urandom(), FULL_WORD);
    endtask

    task automatic test_drain_pause();
        send_item(MODE_START, $urandom(), FULL_WORD);
        send_item(MODE_FINISH, $urandom(), 3'd1);
        send_item(MODE_START_FINISH, $urandom(), 3'd2, 1'b1);
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int msg_words;
        target = sent_items + n_items;
        while (sent_items < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(2'($urandom_range(3)), $urandom(), 3'($urandom_range(7)));
                continue;
            end
            msg_words = ($urandom_range(9) < 7) ? $urandom_range(18) : $urandom_range(45, 19);
            // a message of n words takes n + 1 transactions
            if (msg_words > target - sent_items - 1)
                msg_words = target - sent_items - 1;
            if (msg_words == 0)
            begin
                send_item(MODE_START_FINISH, $urandom(), 3'($urandom_range(7)),
                          $urandom_range(9) == 0);
                continue;
            end
            send_item(MODE_START, $urandom(), full_count(), $urandom_range(9) == 0);
            for (int i = 1; i < msg_words; i++)
            begin
                // now and then a broken word in the middle of a message
                if ($urandom_range(99) < 4)
                    send_item(MODE_CONTINUE, $urandom(), 3'($urandom_range(3)));
                else
                    send_item(MODE_CONTINUE, $urandom(), full_count());
            end
            send_item(MODE_FINISH, $urandom(), 3'($urandom_range(7)));
        end
    endtask

    initial
    begin
        sha1_restart();
        send_idle = 27;
        recv_idle = 85;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_word_messages();
        test_partial_word_errors();
        test_two_block_padding();
        test_drain_pause();
        test_random_traffic(120);

        send_idle = 85;
        recv_idle = 27;
        test_random_traffic(130);

        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(130);

        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && digest_q.size() == 0)
            $display("sha1_hash_with_padding: match");
        else
            $display("sha1_hash_with_padding: mismatch");
        $finish;
    end

endmodule
